// File: src/dtsm_pkg.sv
// ----------------------------------------------------------------------------
// dtsm_pkg
// shared types and codes for the diagonal target sum marker
// ----------------------------------------------------------------------------
`default_nettype none
package dtsm_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [0:0] {
        CFG_GRID_SIDE  = 1'b0,
        CFG_TARGET_SUM = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RDOUT,
        S_CLEAR,
        S_SETUP,
        S_RD,
        S_ACC,
        S_CRD,
        S_CWR,
        S_NEXT,
        S_DONE
    } t_state;

    localparam int DIGIT_W  = 4;
    localparam int SIDE_W   = 7;
    localparam int TARGET_W = 10;
    localparam int SUM_W    = 12;
    localparam int WIDE_W   = 9;

endpackage
`default_nettype wire

// File: src/dtsm_ram.sv
// ----------------------------------------------------------------------------
// dtsm_ram
// generic simple dual-port ram, one write port, registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module dtsm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/diagonal_target_sum_marker_unit.sv
// ----------------------------------------------------------------------------
// diagonal_target_sum_marker_unit
// marks diagonal digit runs of a square grid that sum to a target value
// ----------------------------------------------------------------------------
// usage
//   command channel: a transaction is taken when i_start is high and o_busy
//   is low. load writes one input cell (no result), read returns one output
//   cell, compute scans the grid and returns one result with compute_done set.
//   results appear for exactly one cycle with o_strobe; the receiver cannot
//   stall, so nothing is held back.
//   config channel: i_cfg_valid / o_cfg_ready, always ready; index 0 sets
//   grid_side, index 1 sets target_sum. write only while idle.
// timing
//   load: the next command may follow at once
//   read: result strobed in the cycle right after acceptance (ram latency)
//   compute: a clearing sweep over all 2^(2*clog2(MAX_SIDE)) addresses
//   (4096 by default) of the output ram, then per diagonal a setup and an
//   advance state, a read and an accumulate state per diagonal step, a read
//   and a write state per copied cell, and a final state for the result
// reset
//   grid_side returns to 64, target_sum to 0; the output ram is cleared by a
//   sweep over the same addresses as above, busy held high throughout; the input
//   ram is not initialised
// ----------------------------------------------------------------------------
`default_nettype none
module diagonal_target_sum_marker_unit #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic [1:0] i_action,
    input  wire logic [5:0] i_row_index,
    input  wire logic [5:0] i_column_index,
    input  wire logic [3:0] i_cell_digit,
    output logic            o_strobe,
    output logic [3:0]      o_read_digit,
    output logic            o_compute_done,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [0:0] i_cfg_index,
    input  wire logic [9:0] i_cfg_data
);
    localparam int IW    = $clog2(MAX_SIDE);
    localparam int CW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int WW    = dtsm_pkg::WIDE_W;

    // configuration
    logic [dtsm_pkg::SIDE_W-1:0]   r_grid_side;
    logic [dtsm_pkg::TARGET_W-1:0] r_target;

    // sequencer state
    dtsm_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [CW-1:0]    r_row, n_row, r_col, n_col;   // diagonal origin
    logic             r_dir, n_dir;                 // 0 down-right, 1 down-left
    logic [CW-1:0]    r_k, n_k, r_len, n_len, r_i, n_i;
    logic [CW-1:0]    r_wr, n_wr, r_wc, n_wc;       // walk position
    logic [dtsm_pkg::SUM_W-1:0] r_sum, n_sum;
    logic             r_inside, n_inside;

    // ram ports
    logic                        in_we, out_we;
    logic [AW-1:0]               in_waddr, in_raddr, out_waddr, out_raddr;
    logic [dtsm_pkg::DIGIT_W-1:0] in_rdata, out_rdata, out_wdata;

    logic [WW-1:0]  row_ext, col_ext, side_ext, n_ext;
    logic [CW-1:0]  side_n, down, right, left;
    logic           cmd_ok, addr_inside;
    logic [dtsm_pkg::SUM_W-1:0] sum_new;

    assign cmd_ok      = i_start && !o_busy;
    assign row_ext     = WW'(i_row_index);
    assign col_ext     = WW'(i_column_index);
    assign addr_inside = (row_ext < WW'(MAX_SIDE)) && (col_ext < WW'(MAX_SIDE));
    assign side_ext    = WW'(r_grid_side);
    assign n_ext       = (side_ext > WW'(MAX_SIDE)) ? WW'(MAX_SIDE) : side_ext;
    assign side_n      = n_ext[CW-1:0];
    assign down        = side_n - r_row;
    assign right       = side_n - r_col;
    assign left        = r_col + CW'(1);
    assign sum_new     = r_sum + dtsm_pkg::SUM_W'(in_rdata);

    // configuration writes, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= dtsm_pkg::SIDE_W'(64);
            r_target    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == dtsm_pkg::CFG_GRID_SIDE) begin
                r_grid_side <= i_cfg_data[dtsm_pkg::SIDE_W-1:0];
            end else begin
                r_target <= i_cfg_data;
            end
        end
    end

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_row    = r_row;
        n_col    = r_col;
        n_dir    = r_dir;
        n_k      = r_k;
        n_len    = r_len;
        n_i      = r_i;
        n_wr     = r_wr;
        n_wc     = r_wc;
        n_sum    = r_sum;
        n_inside = r_inside;
        unique case (r_state)
            dtsm_pkg::S_INIT: begin
                // clearing sweep after reset
                n_clr = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = dtsm_pkg::S_IDLE;
                end
            end
            dtsm_pkg::S_IDLE: begin
                if (cmd_ok) begin
                    unique case (dtsm_pkg::t_action'(i_action))
                        dtsm_pkg::ACT_COMPUTE: begin
                            n_state = dtsm_pkg::S_CLEAR;
                            n_clr   = '0;
                        end
                        dtsm_pkg::ACT_READ: begin
                            n_state  = dtsm_pkg::S_RDOUT;
                            n_inside = addr_inside;
                        end
                        default: ;
                    endcase
                end
            end
            dtsm_pkg::S_RDOUT: n_state = dtsm_pkg::S_IDLE;
            dtsm_pkg::S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (&r_clr) begin
                    n_row = '0;
                    n_col = '0;
                    n_dir = 1'b0;
                    n_state = (side_n == '0) ? dtsm_pkg::S_DONE : dtsm_pkg::S_SETUP;
                end
            end
            dtsm_pkg::S_SETUP: begin
                if (!r_dir) begin
                    n_len = (down < right) ? down : right;
                end else begin
                    n_len = (down < left) ? down : left;
                end
                n_k     = '0;
                n_sum   = '0;
                n_wr    = r_row;
                n_wc    = r_col;
                n_state = dtsm_pkg::S_RD;
            end
            dtsm_pkg::S_RD: n_state = dtsm_pkg::S_ACC;
            dtsm_pkg::S_ACC: begin
                n_sum = sum_new;
                if (sum_new == dtsm_pkg::SUM_W'(r_target)) begin
                    // match: copy the prefix from its origin
                    n_i     = '0;
                    n_wr    = r_row;
                    n_wc    = r_col;
                    n_state = dtsm_pkg::S_CRD;
                end else if (r_k + CW'(1) == r_len) begin
                    n_state = dtsm_pkg::S_NEXT;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_wr    = r_wr + CW'(1);
                    n_wc    = r_dir ? r_wc - CW'(1) : r_wc + CW'(1);
                    n_state = dtsm_pkg::S_RD;
                end
            end
            dtsm_pkg::S_CRD: n_state = dtsm_pkg::S_CWR;
            dtsm_pkg::S_CWR: begin
                if (r_i == r_k) begin
                    n_state = dtsm_pkg::S_NEXT;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_wr    = r_wr + CW'(1);
                    n_wc    = r_dir ? r_wc - CW'(1) : r_wc + CW'(1);
                    n_state = dtsm_pkg::S_CRD;
                end
            end
            dtsm_pkg::S_NEXT: begin
                n_state = dtsm_pkg::S_SETUP;
                if (!r_dir) begin
                    n_dir = 1'b1;
                end else begin
                    n_dir = 1'b0;
                    if (r_col + CW'(1) == side_n) begin
                        n_col = '0;
                        if (r_row + CW'(1) == side_n) begin
                            n_state = dtsm_pkg::S_DONE;
                        end else begin
                            n_row = r_row + CW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            dtsm_pkg::S_DONE: n_state = dtsm_pkg::S_IDLE;
            default: n_state = dtsm_pkg::S_IDLE;
        endcase
    end

    // outputs and ram controls
    always_comb begin
        o_busy         = (r_state != dtsm_pkg::S_IDLE);
        o_strobe       = 1'b0;
        o_read_digit   = '0;
        o_compute_done = 1'b0;
        in_we     = cmd_ok && (i_action == dtsm_pkg::ACT_LOAD) && addr_inside;
        in_waddr  = {row_ext[IW-1:0], col_ext[IW-1:0]};
        in_raddr  = {r_wr[IW-1:0], r_wc[IW-1:0]};
        out_raddr = {row_ext[IW-1:0], col_ext[IW-1:0]};
        out_we    = 1'b0;
        out_waddr = r_clr;
        out_wdata = '0;
        unique case (r_state)
            dtsm_pkg::S_RDOUT: begin
                o_strobe     = 1'b1;
                o_read_digit = r_inside ? out_rdata : '0;
            end
            dtsm_pkg::S_DONE: begin
                o_strobe       = 1'b1;
                o_compute_done = 1'b1;
            end
            dtsm_pkg::S_INIT:  out_we = 1'b1;
            dtsm_pkg::S_CLEAR: out_we = 1'b1;
            dtsm_pkg::S_CWR: begin
                out_we    = 1'b1;
                out_waddr = {r_wr[IW-1:0], r_wc[IW-1:0]};
                out_wdata = in_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtsm_pkg::S_INIT;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_row    <= n_row;
        r_col    <= n_col;
        r_dir    <= n_dir;
        r_k      <= n_k;
        r_len    <= n_len;
        r_i      <= n_i;
        r_wr     <= n_wr;
        r_wc     <= n_wc;
        r_sum    <= n_sum;
        r_inside <= n_inside;
    end

    dtsm_ram #(.WIDTH(dtsm_pkg::DIGIT_W), .DEPTH(DEPTH)) u_in_ram (
        .i_clk  (i_clk),
        .i_we   (in_we),
        .i_waddr(in_waddr),
        .i_wdata(i_cell_digit),
        .i_raddr(in_raddr),
        .o_rdata(in_rdata)
    );

    dtsm_ram #(.WIDTH(dtsm_pkg::DIGIT_W), .DEPTH(DEPTH)) u_out_ram (
        .i_clk  (i_clk),
        .i_we   (out_we),
        .i_waddr(out_waddr),
        .i_wdata(out_wdata),
        .i_raddr(out_raddr),
        .o_rdata(out_rdata)
    );

    // a compute transaction always begins with the clearing sweep
    a_compute_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_ok && i_action == dtsm_pkg::ACT_COMPUTE) |=> r_state == dtsm_pkg::S_CLEAR)
        else $error("compute did not start with clear");

    // never two results in consecutive cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back results");

    // copy never runs past the matched prefix
    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtsm_pkg::S_CWR) |-> (r_i <= r_k))
        else $error("copy overran prefix");

endmodule
`default_nettype wire

// File: dv/diagonal_target_sum_marker_unit_tb.sv
// ----------------------------------------------------------------------------
// diagonal_target_sum_marker_unit_tb
// self-checking bench for the diagonal target sum marker: a small grid is
// loaded, computes run under several grid sides and targets, and every read
// and compute result is compared with a cycle-free model of the marking
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module diagonal_target_sum_marker_unit_tb;

    localparam int GRID_MAX = 64;
    // side of the region that is always fully loaded, so no compute
    // ever touches an input cell that was never written
    localparam int LOADED_SIDE = 5;

    typedef struct packed {
        logic [3:0] digit;
        logic       done;
    } t_marker_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [1:0] i_action;
    logic [5:0] i_row_index;
    logic [5:0] i_column_index;
    logic [3:0] i_cell_digit;
    logic       o_strobe;
    logic [3:0] o_read_digit;
    logic       o_compute_done;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [0:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    // marker model state
    logic [3:0] grid_in  [GRID_MAX*GRID_MAX];
    logic [3:0] grid_out [GRID_MAX*GRID_MAX];
    int unsigned side_cfg;
    int unsigned target_cfg;

    t_marker_result pending_results[$];
    int unsigned    mismatch_count;
    int unsigned    sender_gap_pct;

    diagonal_target_sum_marker_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_cell_digit   (i_cell_digit),
        .o_strobe       (o_strobe),
        .o_read_digit   (o_read_digit),
        .o_compute_done (o_compute_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // generous guard on the whole run
    initial begin
        #60_000_000;
        $display("diagonal_target_sum_marker_unit_tb: errors");
        $finish;
    end

    // walk one diagonal, copying the first prefix that hits the target
    task automatic mark_diagonal(input int r, input int c, input int len, input bit leftward);
        int sum;
        int col;
        sum = 0;
        for (int k = 0; k < len; k++) begin
            col = leftward ? c - k : c + k;
            sum += grid_in[(r + k) * GRID_MAX + col];
            if (sum == target_cfg) begin
                for (int i = 0; i <= k; i++) begin
                    col = leftward ? c - i : c + i;
                    grid_out[(r + i) * GRID_MAX + col] = grid_in[(r + i) * GRID_MAX + col];
                end
                return;
            end
        end
    endtask

    task automatic mark_grid();
        int n;
        int down;
        int right;
        int left;
        n = (side_cfg > GRID_MAX) ? GRID_MAX : side_cfg;
        foreach (grid_out[a]) grid_out[a] = '0;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                down  = n - r;
                right = n - c;
                left  = c + 1;
                mark_diagonal(r, c, (down < right) ? down : right, 1'b0);
                mark_diagonal(r, c, (down < left) ? down : left, 1'b1);
            end
        end
    endtask

    // update the model for one accepted transaction
    task automatic predict_marker(input dtsm_pkg::t_action act, input int r, input int c,
                                  input logic [3:0] d);
        t_marker_result res;
        case (act)
            dtsm_pkg::ACT_LOAD: begin
                grid_in[r * GRID_MAX + c] = d;
            end
            dtsm_pkg::ACT_COMPUTE: begin
                mark_grid();
                res.digit = '0;
                res.done  = 1'b1;
                pending_results.push_back(res);
            end
            dtsm_pkg::ACT_READ: begin
                res.digit = grid_out[r * GRID_MAX + c];
                res.done  = 1'b0;
                pending_results.push_back(res);
            end
            default: begin
                // unused action is ignored by the block
            end
        endcase
    endtask

    // one command transaction, followed by an optional sender gap
    task automatic send_cmd(input dtsm_pkg::t_action act, input int r, input int c,
                            input int d);
        i_action       <= act;
        i_row_index    <= r[5:0];
        i_column_index <= c[5:0];
        i_cell_digit   <= d[3:0];
        i_start        <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_marker(act, r, c, d[3:0]);
        if ($urandom_range(99) < sender_gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // hold commands off until every result is back, then let the block settle
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input dtsm_pkg::t_cfg_index idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[9:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == dtsm_pkg::CFG_GRID_SIDE) side_cfg = value & 7'h7f;
        else target_cfg = value & 10'h3ff;
    endtask

    // result checker: the receiver never stalls, so every strobe is a transaction
    always @(posedge i_clk) begin
        t_marker_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: read_digit %0d compute_done %0d",
                       o_read_digit, o_compute_done);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_digit !== want.digit) begin
                    $error("read_digit expected %0d actual %0d", want.digit, o_read_digit);
                    mismatch_count++;
                end
                if (o_compute_done !== want.done) begin
                    $error("compute_done expected %0d actual %0d", want.done,
                           o_compute_done);
                    mismatch_count++;
                end
            end
        end
    end

    // load the whole region in use, digits above nine included
    task automatic test_grid_load();
        int d;
        for (int r = 0; r < LOADED_SIDE; r++) begin
            for (int c = 0; c < LOADED_SIDE; c++) begin
                d = (r * LOADED_SIDE + c) % 11;
                if (r == 2 && c == 2) d = 15;
                if (r == 4 && c == 4) d = 9;
                send_cmd(dtsm_pkg::ACT_LOAD, r, c, d);
            end
        end
        // far corner lies outside the grid in use but is still stored
        send_cmd(dtsm_pkg::ACT_LOAD, 63, 63, 7);
        drain();
    endtask

    task automatic test_directed_compute();
        // reads before any compute see a cleared output grid
        send_cmd(dtsm_pkg::ACT_READ, 0, 0, 0);
        send_cmd(dtsm_pkg::ACT_READ, 63, 63, 0);
        drain();
        cfg_write(dtsm_pkg::CFG_GRID_SIDE, LOADED_SIDE);
        cfg_write(dtsm_pkg::CFG_TARGET_SUM, 9);
        send_cmd(dtsm_pkg::ACT_COMPUTE, 0, 0, 0);
        send_cmd(dtsm_pkg::ACT_READ, 1, 1, 0);
        send_cmd(dtsm_pkg::ACT_READ, 2, 2, 0);
        send_cmd(dtsm_pkg::ACT_READ, 4, 4, 0);
        send_cmd(dtsm_pkg::ACT_READ, 63, 63, 0);
        send_cmd(dtsm_pkg::ACT_NONE, 1, 1, 0);
        drain();
        // target zero marks cells holding zero
        cfg_write(dtsm_pkg::CFG_TARGET_SUM, 0);
        send_cmd(dtsm_pkg::ACT_COMPUTE, 0, 0, 0);
        send_cmd(dtsm_pkg::ACT_READ, 0, 0, 0);
        send_cmd(dtsm_pkg::ACT_READ, 2, 0, 0);
        drain();
        // unreachable target leaves everything zero
        cfg_write(dtsm_pkg::CFG_TARGET_SUM, 1023);
        send_cmd(dtsm_pkg::ACT_COMPUTE, 0, 0, 0);
        send_cmd(dtsm_pkg::ACT_READ, 0, 1, 0);
        drain();
        // grid side zero only clears, side one looks at a single cell
        cfg_write(dtsm_pkg::CFG_TARGET_SUM, 0);
        cfg_write(dtsm_pkg::CFG_GRID_SIDE, 0);
        send_cmd(dtsm_pkg::ACT_COMPUTE, 0, 0, 0);
        send_cmd(dtsm_pkg::ACT_READ, 0, 0, 0);
        drain();
        cfg_write(dtsm_pkg::CFG_GRID_SIDE, 1);
        send_cmd(dtsm_pkg::ACT_COMPUTE, 0, 0, 0);
        send_cmd(dtsm_pkg::ACT_READ, 0, 0, 0);
        drain();
        // largest sides are written, but no compute runs over unloaded cells
        cfg_write(dtsm_pkg::CFG_GRID_SIDE, 64);
        cfg_write(dtsm_pkg::CFG_GRID_SIDE, 127);
        send_cmd(dtsm_pkg::ACT_READ, 42, 21, 0);
        drain();
    endtask

    // loads mostly inside the loaded region, computes under small sides, many reads
    task automatic test_random_phase(input int unsigned gap_pct, input int count);
        int pick;
        int r;
        int c;
        sender_gap_pct = gap_pct;
        cfg_write(dtsm_pkg::CFG_GRID_SIDE, $urandom_range(0, LOADED_SIDE));
        cfg_write(dtsm_pkg::CFG_TARGET_SUM, ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                                     : $urandom_range(0, 30));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                if ($urandom_range(4) == 0) begin
                    r = $urandom_range(63);
                    c = $urandom_range(63);
                end else begin
                    r = $urandom_range(LOADED_SIDE - 1);
                    c = $urandom_range(LOADED_SIDE - 1);
                end
                send_cmd(dtsm_pkg::ACT_LOAD, r, c, $urandom_range(15));
            end else if (pick < 42) begin
                send_cmd(dtsm_pkg::ACT_COMPUTE, $urandom_range(63), $urandom_range(63), 0);
            end else if (pick < 95) begin
                if ($urandom_range(3) == 0) begin
                    r = $urandom_range(63);
                    c = $urandom_range(63);
                end else begin
                    r = $urandom_range(LOADED_SIDE - 1);
                    c = $urandom_range(LOADED_SIDE - 1);
                end
                send_cmd(dtsm_pkg::ACT_READ, r, c, $urandom_range(15));
            end else begin
                send_cmd(dtsm_pkg::ACT_NONE, $urandom_range(63), $urandom_range(63),
                         $urandom_range(15));
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_start        <= 1'b0;
        i_action       <= dtsm_pkg::ACT_LOAD;
        i_row_index    <= '0;
        i_column_index <= '0;
        i_cell_digit   <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= dtsm_pkg::CFG_GRID_SIDE;
        i_cfg_data     <= '0;
        mismatch_count = 0;
        sender_gap_pct = 0;
        side_cfg       = 64;
        target_cfg     = 0;
        foreach (grid_in[a])  grid_in[a]  = '0;
        foreach (grid_out[a]) grid_out[a] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_grid_load();
        test_directed_compute();
        test_random_phase(0, 24);
        test_random_phase(52, 24);
        test_random_phase(0, 24);
        test_random_phase(24, 24);

        drain();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("diagonal_target_sum_marker_unit_tb: clean");
        end else begin
            $display("diagonal_target_sum_marker_unit_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
src/dtsm_pkg.sv
src/dtsm_ram.sv
src/diagonal_target_sum_marker_unit.sv
dv/diagonal_target_sum_marker_unit_tb.sv
